// ----- hw/rtl/lidar_sector_reactive_navigator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the lidar sector navigator
// Shorthands for clocked implication checks with asynchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef LIDAR_SECTOR_REACTIVE_NAVIGATOR_ASSERT_SVH
`define LIDAR_SECTOR_REACTIVE_NAVIGATOR_ASSERT_SVH

// same-cycle implication
`define LSRN_ASSERT_IMP(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("lsrn assertion failed");

// next-cycle implication
`define LSRN_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("lsrn assertion failed");

`endif

// ----- hw/rtl/lsrn_pkg.sv -----
// ----------------------------------------------------------------------------
// lsrn_pkg
// Widths, sector bounds, mode and register codes, and shared structs.
// ----------------------------------------------------------------------------
package lsrn_pkg;

    localparam int DIST_BITS  = 16;
    localparam int TICK_BITS  = 24;
    localparam int SPEED_BITS = 15;
    localparam int RATE_BITS  = 16;
    localparam int MODE_BITS  = 3;
    localparam int IDX_BITS   = 9;
    localparam int CFG_BITS   = 24;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    // sector index windows, low bound inclusive, high bound exclusive
    localparam logic [IDX_BITS-1:0] RIGHT_LO = 9'd260;
    localparam logic [IDX_BITS-1:0] RIGHT_HI = 9'd280;
    localparam logic [IDX_BITS-1:0] FRONT_LO = 9'd340;
    localparam logic [IDX_BITS-1:0] FRONT_HI = 9'd360;
    localparam logic [IDX_BITS-1:0] LEFT_LO  = 9'd80;
    localparam logic [IDX_BITS-1:0] LEFT_HI  = 9'd100;

    localparam logic [MODE_BITS-1:0] MODE_STRAIGHT = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_LEFT     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_RIGHT    = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_AROUND   = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_RETURN   = 3'd4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRONT_THR  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_THR  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_THR   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXIT_THR   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FWD_SPEED  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TURN_RATE  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AROUND_TKS = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RETURN_TKS = 3'd7;

    typedef logic [DIST_BITS-1:0] dist_t;
    typedef logic [TICK_BITS-1:0] tick_t;

    typedef struct packed {
        dist_t                 front_thr;
        dist_t                 right_thr;
        dist_t                 left_thr;
        dist_t                 exit_thr;
        logic [SPEED_BITS-1:0] fwd_speed;
        logic [SPEED_BITS-1:0] turn_rate;
        tick_t                 around_ticks;
        tick_t                 return_ticks;
    } nav_cfg_t;

    typedef struct packed {
        dist_t                front;
        dist_t                right;
        dist_t                left;
        logic [MODE_BITS-1:0] mode;
        tick_t                elapsed;
    } nav_view_t;

    typedef struct packed {
        logic [SPEED_BITS-1:0]       speed;
        logic signed [RATE_BITS-1:0] rate;
        logic [MODE_BITS-1:0]        shown;
        logic [MODE_BITS-1:0]        next_mode;
        tick_t                       next_elapsed;
    } nav_cmd_t;

endpackage

// ----- hw/rtl/lsrn_decide.sv -----
// ----------------------------------------------------------------------------
// lsrn_decide
// Scan-end decision: direction choice, exit detection, timed turn-around
// and return, and the velocity command for the shown mode.
// ----------------------------------------------------------------------------
module lsrn_decide (
    input  lsrn_pkg::nav_cfg_t  cfg,
    input  lsrn_pkg::nav_view_t view,
    output lsrn_pkg::nav_cmd_t  cmd
);
    import lsrn_pkg::*;

    logic [MODE_BITS-1:0]        dir_mode;
    logic [MODE_BITS-1:0]        shown_mode;
    tick_t                       elapsed_eff;
    logic signed [RATE_BITS-1:0] rate_pos;
    logic signed [RATE_BITS-1:0] rate_neg;
    logic                        exit_open;

    assign rate_pos  = {1'b0, cfg.turn_rate};
    assign rate_neg  = RATE_BITS'(0) - rate_pos;
    assign exit_open = (view.front > cfg.front_thr) && (view.right > cfg.exit_thr)
                       && (view.left > cfg.exit_thr);

    always_comb
    begin
        dir_mode = view.mode;
        if (view.mode != MODE_AROUND && view.mode != MODE_RETURN)
        begin
            if (((view.front > view.left) || (view.front > view.right))
                && (view.front > cfg.front_thr))
            begin
                dir_mode = MODE_STRAIGHT;
            end
            else if ((view.right > view.front) && (view.right > cfg.right_thr))
            begin
                dir_mode = MODE_RIGHT;
            end
            else if ((view.left > view.front) && (view.left > cfg.left_thr))
            begin
                dir_mode = MODE_LEFT;
            end
            else
            begin
                dir_mode = MODE_STRAIGHT;
            end
        end

        shown_mode  = dir_mode;
        elapsed_eff = view.elapsed;
        if ((dir_mode == MODE_STRAIGHT || dir_mode == MODE_LEFT || dir_mode == MODE_RIGHT)
            && exit_open)
        begin
            shown_mode  = MODE_AROUND;
            elapsed_eff = '0;
        end

        cmd.speed        = '0;
        cmd.rate         = '0;
        cmd.shown        = shown_mode;
        cmd.next_mode    = shown_mode;
        cmd.next_elapsed = elapsed_eff;
        case (shown_mode)
            MODE_STRAIGHT:
            begin
                cmd.speed = cfg.fwd_speed;
            end
            MODE_LEFT:
            begin
                cmd.rate = rate_pos;
            end
            MODE_RIGHT:
            begin
                cmd.rate = rate_neg;
            end
            MODE_AROUND:
            begin
                cmd.rate = rate_neg;
                if (elapsed_eff > cfg.around_ticks)
                begin
                    cmd.next_mode    = MODE_RETURN;
                    cmd.next_elapsed = '0;
                end
            end
            default:
            begin
                cmd.speed = cfg.fwd_speed;
                if (elapsed_eff > cfg.return_ticks)
                begin
                    cmd.next_mode = MODE_STRAIGHT;
                end
            end
        endcase
    end

endmodule

// ----- hw/rtl/lidar_sector_reactive_navigator.sv -----
// ----------------------------------------------------------------------------
// lidar_sector_reactive_navigator
// A scan-end sample passes through the input register, then the result register.
// Throughput: one item per cycle unless a result stalls; the input register feeds the
// sector/decision logic and the output register, so a stall holds only the item behind it.
// Reset: config to defaults, mode straight, minima all ones, elapsed zero.
// ----------------------------------------------------------------------------
`include "lidar_sector_reactive_navigator_assert.svh"

module lidar_sector_reactive_navigator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [lsrn_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [lsrn_pkg::CFG_BITS-1:0]          cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   kind,
    input  logic [lsrn_pkg::IDX_BITS-1:0]          sample_index,
    input  logic [lsrn_pkg::DIST_BITS-1:0]         distance_mm,
    input  logic                                   scan_end,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [lsrn_pkg::SPEED_BITS-1:0]        speed_cmd,
    output logic signed [lsrn_pkg::RATE_BITS-1:0]  rate_cmd,
    output logic [lsrn_pkg::MODE_BITS-1:0]         mode,
    output logic [lsrn_pkg::DIST_BITS-1:0]         front_min_mm,
    output logic [lsrn_pkg::DIST_BITS-1:0]         right_min_mm,
    output logic [lsrn_pkg::DIST_BITS-1:0]         left_min_mm
);
    import lsrn_pkg::*;

    nav_cfg_t cfg_reg;

    // input register
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_kind_reg;
    logic [IDX_BITS-1:0]   s1_index_reg;
    dist_t                 s1_dist_reg;
    logic                  s1_end_reg;

    // navigation state
    logic [MODE_BITS-1:0]  mode_reg, mode_next;
    dist_t                 front_reg, front_next;
    dist_t                 right_reg, right_next;
    dist_t                 left_reg, left_next;
    tick_t                 elapsed_reg, elapsed_next;

    // result register
    logic                        out_valid_reg, out_valid_next;
    logic [SPEED_BITS-1:0]       out_speed_reg;
    logic signed [RATE_BITS-1:0] out_rate_reg;
    logic [MODE_BITS-1:0]        out_mode_reg;
    dist_t                       out_front_reg;
    dist_t                       out_right_reg;
    dist_t                       out_left_reg;

    logic      in_fire;
    logic      s1_result;
    logic      s1_go;
    logic      load_out;
    dist_t     front_upd, right_upd, left_upd;
    nav_view_t view;
    nav_cmd_t  cmd;

    assign s1_result = s1_valid_reg && !s1_kind_reg && s1_end_reg;
    assign s1_go     = s1_valid_reg && (!s1_result || !out_valid_reg || out_ready);
    assign load_out  = s1_go && s1_result;
    assign in_ready  = !s1_valid_reg || s1_go;
    assign in_fire   = in_valid && in_ready;

    // sector minima including the sample in the input register
    always_comb
    begin
        front_upd = front_reg;
        right_upd = right_reg;
        left_upd  = left_reg;
        if (s1_index_reg >= RIGHT_LO && s1_index_reg < RIGHT_HI)
        begin
            if (s1_dist_reg < right_reg)
            begin
                right_upd = s1_dist_reg;
            end
        end
        else if (s1_index_reg >= FRONT_LO && s1_index_reg < FRONT_HI)
        begin
            if (s1_dist_reg < front_reg)
            begin
                front_upd = s1_dist_reg;
            end
        end
        else if (s1_index_reg >= LEFT_LO && s1_index_reg < LEFT_HI)
        begin
            if (s1_dist_reg < left_reg)
            begin
                left_upd = s1_dist_reg;
            end
        end
    end

    assign view.front   = front_upd;
    assign view.right   = right_upd;
    assign view.left    = left_upd;
    assign view.mode    = mode_reg;
    assign view.elapsed = elapsed_reg;

    lsrn_decide u_decide (
        .cfg  (cfg_reg),
        .view (view),
        .cmd  (cmd)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        mode_next    = mode_reg;
        front_next   = front_reg;
        right_next   = right_reg;
        left_next    = left_reg;
        elapsed_next = elapsed_reg;
        if (s1_go)
        begin
            if (s1_kind_reg)
            begin
                if (elapsed_reg != TICK_MAX)
                begin
                    elapsed_next = elapsed_reg + TICK_BITS'(1);
                end
            end
            else if (s1_end_reg)
            begin
                mode_next    = cmd.next_mode;
                elapsed_next = cmd.next_elapsed;
                front_next   = DIST_MAX;
                right_next   = DIST_MAX;
                left_next    = DIST_MAX;
            end
            else
            begin
                front_next = front_upd;
                right_next = right_upd;
                left_next  = left_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.front_thr    <= 16'd1500;
            cfg_reg.right_thr    <= 16'd1500;
            cfg_reg.left_thr     <= 16'd1500;
            cfg_reg.exit_thr     <= 16'd1500;
            cfg_reg.fwd_speed    <= 15'd800;
            cfg_reg.turn_rate    <= 15'd400;
            cfg_reg.around_ticks <= 24'd8639;
            cfg_reg.return_ticks <= 24'd2000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRONT_THR:  cfg_reg.front_thr    <= cfg_data[DIST_BITS-1:0];
                CFG_RIGHT_THR:  cfg_reg.right_thr    <= cfg_data[DIST_BITS-1:0];
                CFG_LEFT_THR:   cfg_reg.left_thr     <= cfg_data[DIST_BITS-1:0];
                CFG_EXIT_THR:   cfg_reg.exit_thr     <= cfg_data[DIST_BITS-1:0];
                CFG_FWD_SPEED:  cfg_reg.fwd_speed    <= cfg_data[SPEED_BITS-1:0];
                CFG_TURN_RATE:  cfg_reg.turn_rate    <= cfg_data[SPEED_BITS-1:0];
                CFG_AROUND_TKS: cfg_reg.around_ticks <= cfg_data[TICK_BITS-1:0];
                CFG_RETURN_TKS: cfg_reg.return_ticks <= cfg_data[TICK_BITS-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_STRAIGHT;
            front_reg     <= DIST_MAX;
            right_reg     <= DIST_MAX;
            left_reg      <= DIST_MAX;
            elapsed_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            front_reg     <= front_next;
            right_reg     <= right_next;
            left_reg      <= left_next;
            elapsed_reg   <= elapsed_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg  <= kind;
            s1_index_reg <= sample_index;
            s1_dist_reg  <= distance_mm;
            s1_end_reg   <= scan_end;
        end
        if (load_out)
        begin
            out_speed_reg <= cmd.speed;
            out_rate_reg  <= cmd.rate;
            out_mode_reg  <= cmd.shown;
            out_front_reg <= front_upd;
            out_right_reg <= right_upd;
            out_left_reg  <= left_upd;
        end
    end

    assign out_valid    = out_valid_reg;
    assign speed_cmd    = out_speed_reg;
    assign rate_cmd     = out_rate_reg;
    assign mode         = out_mode_reg;
    assign front_min_mm = out_front_reg;
    assign right_min_mm = out_right_reg;
    assign left_min_mm  = out_left_reg;

    `LSRN_ASSERT_IMP(a_mode_legal, clk, rst_n, out_valid_reg, (out_mode_reg <= MODE_RETURN))
    `LSRN_ASSERT_IMP(a_cmd_exclusive, clk, rst_n, out_valid_reg, (out_speed_reg == '0 || out_rate_reg == '0))
    `LSRN_ASSERT_NEXT(a_minima_cleared, clk, rst_n, load_out, (front_reg == DIST_MAX && right_reg == DIST_MAX && left_reg == DIST_MAX))
    `LSRN_ASSERT_NEXT(a_elapsed_sat, clk, rst_n, (s1_go && s1_kind_reg && elapsed_reg == TICK_MAX), (elapsed_reg == TICK_MAX))

endmodule
